FILE: hdl/sha1_message_hasher_core_assert.svh
// Assertion macros for the SHA-1 message hasher core.
`ifndef SHA1_MESSAGE_HASHER_CORE_ASSERT_SVH
`define SHA1_MESSAGE_HASHER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define SMH_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("smh: same-cycle check failed");
// Next-cycle implication, disabled while reset is asserted.
`define SMH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("smh: next-cycle check failed");
`else
`define SMH_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define SMH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: hdl/smh_pkg.sv
// Shared types and constants for the SHA-1 message hasher.
`default_nettype none
package smh_pkg;
	localparam int WIN_DEPTH = 16;
	localparam int WIN_AW    = $clog2(WIN_DEPTH);

	typedef logic [31:0] word_t;

	// SHA-1 initial chaining value
	localparam word_t IV0 = 32'h67452301;
	localparam word_t IV1 = 32'hEFCDAB89;
	localparam word_t IV2 = 32'h98BADCFE;
	localparam word_t IV3 = 32'h10325476;
	localparam word_t IV4 = 32'hC3D2E1F0;

	// round constants, one per group of twenty rounds
	localparam word_t K0 = 32'h5A827999;
	localparam word_t K1 = 32'h6ED9EBA1;
	localparam word_t K2 = 32'h8F1BBCDC;
	localparam word_t K3 = 32'hCA62C1D6;

	localparam logic [7:0] PAD_MARK = 8'h80;

	// access request to the schedule window memory
	typedef struct packed {
		logic              we;
		logic [WIN_AW-1:0] waddr;
		word_t             wdata;
		logic [WIN_AW-1:0] raddr_a;
		logic [WIN_AW-1:0] raddr_b;
	} mem_req_t;
endpackage
`default_nettype wire

FILE: hdl/smh_window.sv
// Sixteen-word schedule window: one write port, two registered read ports.
`default_nettype none
module smh_window (
	input  logic             clk,
	input  smh_pkg::mem_req_t req,
	output smh_pkg::word_t    rdata_a,
	output smh_pkg::word_t    rdata_b
);
	import smh_pkg::*;

	word_t mem [WIN_DEPTH];
	word_t rdata_a_q;
	word_t rdata_b_q;

	// write one word, read two words through output registers
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		rdata_a_q <= mem[req.raddr_a];
		rdata_b_q <= mem[req.raddr_b];
	end

	assign rdata_a = rdata_a_q;
	assign rdata_b = rdata_b_q;
endmodule
`default_nettype wire

FILE: hdl/sha1_message_hasher_core.sv
// SHA-1 message hasher: byte packing, padding, round sequencer and digest output.
`default_nettype none
`include "sha1_message_hasher_core_assert.svh"
// Each request carries at most one message byte; a byte request is taken while
// msg_stall is low. When a byte fills a 64-byte block the core compresses it
// (rounds 0..15 run phases A and B, rounds 16..79 run phases A, B and C, plus
// one chaining add), with msg_stall high. Round cost is set by the schedule window
// memory: it has two read ports and each extended round needs four window words.
// An end-of-message request starts padding, pushed one byte per cycle except while
// a compression runs, with one or two compressions; the digest then sits in an
// output register, and new message requests are taken while it waits to be read.
module sha1_message_hasher_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           msg_valid,
	output logic           msg_stall,
	input  logic [7:0]     data_byte,
	input  logic           has_byte,
	input  logic           end_of_message,
	output logic           digest_valid,
	input  logic           digest_stall,
	output smh_pkg::word_t digest_word0,
	output smh_pkg::word_t digest_word1,
	output smh_pkg::word_t digest_word2,
	output smh_pkg::word_t digest_word3,
	output smh_pkg::word_t digest_word4
);
	import smh_pkg::*;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_ROUND = 2'd1;
	localparam logic [1:0] S_ADD   = 2'd2;
	localparam logic [1:0] S_PAD   = 2'd3;

	localparam logic [1:0] PH_A = 2'd0;
	localparam logic [1:0] PH_B = 2'd1;
	localparam logic [1:0] PH_C = 2'd2;

	localparam logic [6:0] ROUND_LAST  = 7'd79;
	localparam logic [6:0] SCHED_START = 7'd16;

	logic [1:0]  state_q;
	logic [6:0]  round_q;
	logic [1:0]  phase_q;
	logic [5:0]  pos_q;
	logic [60:0] count_q;
	logic        pad_pending_q;
	logic        pad_first_q;
	logic        len_zone_q;
	logic        len_done_q;
	logic        digest_valid_q;
	word_t       h_q [5];
	word_t       a_q, b_q, c_q, d_q, e_q;
	word_t       pack_q;
	word_t       xor_q;
	word_t       out_q [5];

	mem_req_t    mem_req;
	word_t       rd_a, rd_b;

	logic        push_en;
	logic [7:0]  push_byte;
	logic        block_done;
	logic        len_active;
	logic [63:0] len_bits;
	logic [7:0]  len_byte;
	word_t       pack_next;
	logic [3:0]  ridx;
	logic        sched;
	logic        last_phase;
	word_t       xw;
	word_t       w_cur;
	word_t       f_val;
	word_t       k_val;
	word_t       t_val;
	word_t       sum [5];
	logic        out_free;
	logic        emit;

	smh_window u_window (
		.clk     (clk),
		.req     (mem_req),
		.rdata_a (rd_a),
		.rdata_b (rd_b)
	);

	// pick the byte to pack: message byte when idle, padding mark, zero or length byte while padding
	assign len_bits   = {count_q, 3'b000};
	assign len_byte   = len_bits[{~pos_q[2:0], 3'b000} +: 8];
	assign len_active = len_zone_q || (pos_q == 6'd56);

	always_comb begin
		push_en   = 1'b0;
		push_byte = data_byte;
		case (state_q)
			S_IDLE: begin
				push_en = msg_valid && has_byte;
			end
			S_PAD: begin
				push_en = 1'b1;
				if (pad_first_q) begin
					push_byte = PAD_MARK;
				end else if (len_active) begin
					push_byte = len_byte;
				end else begin
					push_byte = 8'h00;
				end
			end
			default: begin
				push_en = 1'b0;
			end
		endcase
	end

	assign block_done = push_en && (pos_q == 6'd63);
	assign pack_next  = {pack_q[23:0], push_byte};

	// round datapath
	assign ridx       = round_q[3:0];
	assign sched      = (round_q >= SCHED_START);
	assign last_phase = sched ? (phase_q == PH_C) : (phase_q == PH_B);
	assign xw         = xor_q ^ rd_a ^ rd_b;
	assign w_cur      = sched ? {xw[30:0], xw[31]} : rd_a;

	always_comb begin
		if (round_q < 7'd20) begin
			f_val = (b_q & c_q) | (~b_q & d_q);
			k_val = K0;
		end else if (round_q < 7'd40) begin
			f_val = b_q ^ c_q ^ d_q;
			k_val = K1;
		end else if (round_q < 7'd60) begin
			f_val = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k_val = K2;
		end else begin
			f_val = b_q ^ c_q ^ d_q;
			k_val = K3;
		end
	end

	assign t_val = {a_q[26:0], a_q[31:27]} + f_val + e_q + w_cur + k_val;

	// window access: schedule write in the last phase of rounds 16..79, byte word write outside the rounds
	always_comb begin
		mem_req.we      = 1'b0;
		mem_req.waddr   = pos_q[5:2];
		mem_req.wdata   = pack_next;
		mem_req.raddr_a = ridx;
		mem_req.raddr_b = ridx + 4'd2;
		if (state_q == S_ROUND) begin
			if (phase_q == PH_B) begin
				mem_req.raddr_a = ridx + 4'd8;
				mem_req.raddr_b = ridx + 4'd13;
			end
			if (last_phase && sched) begin
				mem_req.we    = 1'b1;
				mem_req.waddr = ridx;
				mem_req.wdata = w_cur;
			end
		end else begin
			mem_req.we = push_en && (pos_q[1:0] == 2'b11);
		end
	end

	// chaining add and digest release
	assign sum[0]   = h_q[0] + a_q;
	assign sum[1]   = h_q[1] + b_q;
	assign sum[2]   = h_q[2] + c_q;
	assign sum[3]   = h_q[3] + d_q;
	assign sum[4]   = h_q[4] + e_q;
	assign out_free = !digest_valid_q || !digest_stall;
	assign emit     = (state_q == S_ADD) && len_done_q && out_free;

	assign msg_stall = (state_q != S_IDLE);

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			round_q        <= '0;
			phase_q        <= PH_A;
			pos_q          <= '0;
			count_q        <= '0;
			pad_pending_q  <= 1'b0;
			pad_first_q    <= 1'b0;
			len_zone_q     <= 1'b0;
			len_done_q     <= 1'b0;
			digest_valid_q <= 1'b0;
			h_q[0]         <= IV0;
			h_q[1]         <= IV1;
			h_q[2]         <= IV2;
			h_q[3]         <= IV3;
			h_q[4]         <= IV4;
		end else begin
			// drop the digest once taken, load a new one on release
			if (emit) begin
				digest_valid_q <= 1'b1;
			end else if (!digest_stall) begin
				digest_valid_q <= 1'b0;
			end

			if (push_en) begin
				pos_q <= pos_q + 6'd1;
			end

			case (state_q)
				S_IDLE: begin
					if (msg_valid) begin
						if (has_byte) begin
							count_q <= count_q + 61'd1;
						end
						if (block_done) begin
							state_q       <= S_ROUND;
							round_q       <= '0;
							phase_q       <= PH_A;
							pad_pending_q <= end_of_message;
							pad_first_q   <= end_of_message;
						end else if (end_of_message) begin
							state_q       <= S_PAD;
							pad_pending_q <= 1'b1;
							pad_first_q   <= 1'b1;
						end
					end
				end
				S_PAD: begin
					if (pad_first_q) begin
						pad_first_q <= 1'b0;
					end else if (len_active) begin
						len_zone_q <= 1'b1;
						if (pos_q == 6'd63) begin
							len_done_q <= 1'b1;
						end
					end
					if (block_done) begin
						state_q <= S_ROUND;
						round_q <= '0;
						phase_q <= PH_A;
					end
				end
				S_ROUND: begin
					if (last_phase) begin
						phase_q <= PH_A;
						if (round_q == ROUND_LAST) begin
							round_q <= '0;
							state_q <= S_ADD;
						end else begin
							round_q <= round_q + 7'd1;
						end
					end else begin
						phase_q <= phase_q + 2'd1;
					end
				end
				S_ADD: begin
					if (!len_done_q) begin
						h_q[0]  <= sum[0];
						h_q[1]  <= sum[1];
						h_q[2]  <= sum[2];
						h_q[3]  <= sum[3];
						h_q[4]  <= sum[4];
						state_q <= pad_pending_q ? S_PAD : S_IDLE;
					end else if (out_free) begin
						// hand out the digest and restart the chain
						h_q[0]        <= IV0;
						h_q[1]        <= IV1;
						h_q[2]        <= IV2;
						h_q[3]        <= IV3;
						h_q[4]        <= IV4;
						count_q       <= '0;
						pad_pending_q <= 1'b0;
						len_zone_q    <= 1'b0;
						len_done_q    <= 1'b0;
						state_q       <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload: byte packing, working words, schedule partial and digest
	always_ff @(posedge clk) begin
		if (push_en) begin
			pack_q <= pack_next;
		end
		if (state_q == S_ROUND && phase_q == PH_B && sched) begin
			xor_q <= rd_a ^ rd_b;
		end
		if (block_done) begin
			a_q <= h_q[0];
			b_q <= h_q[1];
			c_q <= h_q[2];
			d_q <= h_q[3];
			e_q <= h_q[4];
		end else if (state_q == S_ROUND && last_phase) begin
			a_q <= t_val;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
		end
		if (emit) begin
			out_q[0] <= sum[0];
			out_q[1] <= sum[1];
			out_q[2] <= sum[2];
			out_q[3] <= sum[3];
			out_q[4] <= sum[4];
		end
	end

	assign digest_valid = digest_valid_q;
	assign digest_word0 = out_q[0];
	assign digest_word1 = out_q[1];
	assign digest_word2 = out_q[2];
	assign digest_word3 = out_q[3];
	assign digest_word4 = out_q[4];

	// checks on the sequencer
	`SMH_ASSERT_IMPL(a_round_range, clk, arst_n, state_q == S_ROUND, round_q <= ROUND_LAST)
	`SMH_ASSERT_IMPL(a_block_aligned, clk, arst_n, state_q == S_ROUND, pos_q == 6'd0)
	`SMH_ASSERT_IMPL(a_sched_write, clk, arst_n, state_q == S_ROUND && mem_req.we, round_q >= SCHED_START && phase_q == PH_C)
	`SMH_ASSERT_NEXT(a_emit, clk, arst_n, emit, digest_valid && state_q == S_IDLE && count_q == 61'd0)
endmodule
`default_nettype wire
